// ----- rtl/cbm_pkg.sv -----
// Shared types and constants for the cartridge bank mapper.
// Used by cbm_regs, cbm_map, cartridge_bank_mapper_irq and tb_top; no dependencies.
package cbm_pkg;

  localparam int CHR_SLOTS = 8;
  localparam int CHR_SEL_W = $clog2(CHR_SLOTS);
  localparam int PRG_SLOTS = 3;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_CPU_TICK  = 2'd1,
    OP_CPU_READ  = 2'd2,
    OP_PPU_READ  = 2'd3
  } op_t;

  // 6000h slot modes
  typedef enum logic [1:0] {
    MODE_ROM  = 2'd0,
    MODE_RAM  = 2'd1,
    MODE_NONE = 2'd2
  } slot_mode_t;

  // Target memory kinds
  typedef enum logic [1:0] {
    KIND_PRG_ROM = 2'd0,
    KIND_PRG_RAM = 2'd1,
    KIND_CHR     = 2'd2,
    KIND_NT      = 2'd3
  } mem_kind_t;

  // Mirroring modes
  localparam logic [1:0] MIR_VERT  = 2'd0;
  localparam logic [1:0] MIR_HORZ  = 2'd1;
  localparam logic [1:0] MIR_LOW   = 2'd2;
  localparam logic [1:0] MIR_HIGH  = 2'd3;

  // Parameter command codes (0-7 are CHR banks)
  localparam logic [3:0] CMD_SLOT     = 4'h8;
  localparam logic [3:0] CMD_PRG0     = 4'h9;
  localparam logic [3:0] CMD_PRG1     = 4'hA;
  localparam logic [3:0] CMD_PRG2     = 4'hB;
  localparam logic [3:0] CMD_MIRROR   = 4'hC;
  localparam logic [3:0] CMD_IRQ_CTRL = 4'hD;
  localparam logic [3:0] CMD_CNT_LO   = 4'hE;
  localparam logic [3:0] CMD_CNT_HI   = 4'hF;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_ROM_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_RAM_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_MASK     = 3'd3;

  // CPU address windows, by A15..A13
  localparam logic [2:0] WIN_SLOT  = 3'b011;
  localparam logic [2:0] WIN_CMD   = 3'b100;
  localparam logic [2:0] WIN_PARAM = 3'b101;
  localparam logic [2:0] WIN_ASEL  = 3'b110;
  localparam logic [2:0] WIN_ADATA = 3'b111;

  // Sound register numbers that are forwarded
  localparam logic [3:0] AUD_LAST_LO = 4'h5;
  localparam logic [3:0] AUD_FIRST_HI = 4'h7;
  localparam logic [3:0] AUD_LAST_HI = 4'hA;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] address;
    logic [7:0]  data;
  } cbm_item_t;

  // Mapping state seen by the address decoder
  typedef struct packed {
    logic [5:0]                     prg_rom_mask;
    logic [5:0]                     prg_ram_mask;
    logic                           ram_present;
    logic [7:0]                     chr_mask;
    logic [CHR_SLOTS-1:0][7:0]      chr_banks;
    logic [PRG_SLOTS-1:0][5:0]      prg_banks;
    logic [5:0]                     low_slot_bank;
    slot_mode_t                     low_slot_mode;
    logic                           ram_we;
    logic [1:0]                     mirroring;
    logic [3:0]                     audio_select;
  } cbm_state_t;

  typedef struct packed {
    logic        mem_valid;
    mem_kind_t   mem_kind;
    logic [18:0] mem_offset;
    logic        ram_write_strobe;
    logic        audio_strobe;
    logic [3:0]  audio_reg;
    logic [7:0]  audio_data;
  } cbm_result_t;

endpackage

// ----- rtl/cbm_regs.sv -----
// Mapper register file: configuration, bank/command registers and IRQ counter.
// Depends on cbm_pkg.
module cbm_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          step_en,
  input  cbm_pkg::cbm_item_t            item,
  output cbm_pkg::cbm_state_t           st,
  output logic                          irq_level_nxt
);
  import cbm_pkg::*;

  cbm_state_t  st_r, st_nxt;
  logic [3:0]  cmd_r, cmd_nxt;
  logic        irq_en_r, irq_en_nxt;
  logic        cnt_en_r, cnt_en_nxt;
  logic        ack_r, ack_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        irq_r;
  logic [2:0]  win;
  logic [7:0]  v;

  assign win = item.address[15:13];
  assign v   = item.data;

  // Next-state logic for one processed request and config writes
  always_comb begin
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    irq_en_nxt    = irq_en_r;
    cnt_en_nxt    = cnt_en_r;
    ack_nxt       = ack_r;
    cnt_nxt       = cnt_r;
    irq_level_nxt = irq_r;

    if (step_en) begin
      case (item.opcode)
        OP_CPU_WRITE: begin
          if (win == WIN_CMD) begin
            cmd_nxt = v[3:0];
          end else if (win == WIN_ASEL) begin
            st_nxt.audio_select = v[3:0];
          end else if (win == WIN_PARAM) begin
            if (!cmd_r[3]) begin
              st_nxt.chr_banks[cmd_r[CHR_SEL_W-1:0]] = v;
            end else begin
              case (cmd_r)
                CMD_SLOT: begin
                  st_nxt.ram_we        = v[7];
                  st_nxt.low_slot_bank = v[5:0];
                  if (v[6]) st_nxt.low_slot_mode = v[7] ? MODE_RAM : MODE_NONE;
                  else      st_nxt.low_slot_mode = MODE_ROM;
                end
                CMD_PRG0:     st_nxt.prg_banks[0] = v[5:0];
                CMD_PRG1:     st_nxt.prg_banks[1] = v[5:0];
                CMD_PRG2:     st_nxt.prg_banks[2] = v[5:0];
                CMD_MIRROR:   st_nxt.mirroring = v[1:0];
                CMD_IRQ_CTRL: begin
                  irq_en_nxt = v[0];
                  cnt_en_nxt = v[7];
                  ack_nxt    = 1'b1;
                end
                CMD_CNT_LO:   cnt_nxt = {cnt_r[15:8], v};
                CMD_CNT_HI:   cnt_nxt = {v, cnt_r[7:0]};
                default:      cmd_nxt = cmd_r;
              endcase
            end
          end
        end
        OP_CPU_TICK: begin
          // acknowledge first, then count; wrap from zero sets the line to the IRQ enable
          if (ack_r) begin
            irq_level_nxt = 1'b0;
            ack_nxt       = 1'b0;
          end
          if (cnt_en_r) begin
            cnt_nxt = cnt_r - 16'd1;
            if (cnt_r == 16'd0) irq_level_nxt = irq_en_r;
          end
        end
        default: cmd_nxt = cmd_r;
      endcase
    end

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_ROM_MASK: st_nxt.prg_rom_mask = cfg_wdata[5:0];
        CFG_PRG_RAM_MASK: st_nxt.prg_ram_mask = cfg_wdata[5:0];
        CFG_RAM_PRESENT:  st_nxt.ram_present  = cfg_wdata[0];
        CFG_CHR_MASK:     st_nxt.chr_mask     = cfg_wdata;
        default:          st_nxt.chr_mask     = st_r.chr_mask;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.prg_rom_mask  <= 6'h3F;
      st_r.prg_ram_mask  <= 6'h00;
      st_r.ram_present   <= 1'b1;
      st_r.chr_mask      <= 8'hFF;
      st_r.chr_banks     <= '0;
      st_r.prg_banks     <= '0;
      st_r.low_slot_bank <= 6'h00;
      st_r.low_slot_mode <= MODE_RAM;
      st_r.ram_we        <= 1'b0;
      st_r.mirroring     <= MIR_VERT;
      st_r.audio_select  <= 4'h0;
      cmd_r              <= 4'h0;
      irq_en_r           <= 1'b0;
      cnt_en_r           <= 1'b0;
      ack_r              <= 1'b0;
      cnt_r              <= 16'h0000;
      irq_r              <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cmd_r    <= cmd_nxt;
      irq_en_r <= irq_en_nxt;
      cnt_en_r <= cnt_en_nxt;
      ack_r    <= ack_nxt;
      cnt_r    <= cnt_nxt;
      irq_r    <= irq_level_nxt;
    end
  end

  assign st = st_r;

endmodule

// ----- rtl/cbm_map.sv -----
// Address decoder: CPU/PPU lookups, PRG RAM writes and sound register forwarding.
// Depends on cbm_pkg; purely combinational.
module cbm_map (
  input  cbm_pkg::cbm_item_t   item,
  input  cbm_pkg::cbm_state_t  st,
  output cbm_pkg::cbm_result_t res
);
  import cbm_pkg::*;

  logic [15:0] a;
  logic [2:0]  win;
  logic [5:0]  prg_bank;
  logic [5:0]  slot_rom_bank;
  logic [5:0]  slot_ram_bank;
  logic [7:0]  chr_bank;
  logic        page;
  logic        slot_ram_ok;

  assign a   = item.address;
  assign win = a[15:13];

  assign slot_rom_bank = st.low_slot_bank & st.prg_rom_mask;
  assign slot_ram_bank = st.low_slot_bank & st.prg_ram_mask;
  assign slot_ram_ok   = (st.low_slot_mode == MODE_RAM) && st.ram_present;
  assign chr_bank      = st.chr_banks[a[10+CHR_SEL_W-1:10]] & st.chr_mask;

  // Switchable 8KB PRG bank for 8000h-DFFFh, fixed last bank above
  always_comb begin
    case (win)
      WIN_CMD:   prg_bank = st.prg_banks[0] & st.prg_rom_mask;
      WIN_PARAM: prg_bank = st.prg_banks[1] & st.prg_rom_mask;
      WIN_ASEL:  prg_bank = st.prg_banks[2] & st.prg_rom_mask;
      default:   prg_bank = st.prg_rom_mask;
    endcase
  end

  // Nametable page select
  always_comb begin
    case (st.mirroring)
      MIR_VERT: page = a[10];
      MIR_HORZ: page = a[11];
      MIR_LOW:  page = 1'b0;
      default:  page = 1'b1;
    endcase
  end

  always_comb begin
    res = '0;
    case (item.opcode)
      OP_CPU_WRITE: begin
        if (win == WIN_SLOT) begin
          if (slot_ram_ok && st.ram_we) begin
            res.mem_valid        = 1'b1;
            res.mem_kind         = KIND_PRG_RAM;
            res.mem_offset       = {slot_ram_bank, a[12:0]};
            res.ram_write_strobe = 1'b1;
          end
        end else if (win == WIN_ADATA) begin
          if (st.audio_select <= AUD_LAST_LO ||
              (st.audio_select >= AUD_FIRST_HI && st.audio_select <= AUD_LAST_HI)) begin
            res.audio_strobe = 1'b1;
            res.audio_reg    = st.audio_select;
            res.audio_data   = item.data;
          end
        end
      end
      OP_CPU_READ: begin
        if (win == WIN_SLOT) begin
          if (st.low_slot_mode == MODE_ROM) begin
            res.mem_valid  = 1'b1;
            res.mem_kind   = KIND_PRG_ROM;
            res.mem_offset = {slot_rom_bank, a[12:0]};
          end else if (slot_ram_ok) begin
            res.mem_valid  = 1'b1;
            res.mem_kind   = KIND_PRG_RAM;
            res.mem_offset = {slot_ram_bank, a[12:0]};
          end
        end else if (a[15]) begin
          res.mem_valid  = 1'b1;
          res.mem_kind   = KIND_PRG_ROM;
          res.mem_offset = {prg_bank, a[12:0]};
        end
      end
      OP_PPU_READ: begin
        if (!a[13]) begin
          res.mem_valid  = 1'b1;
          res.mem_kind   = KIND_CHR;
          res.mem_offset = {1'b0, chr_bank, a[9:0]};
        end else if (a[13:8] != 6'h3F) begin
          res.mem_valid  = 1'b1;
          res.mem_kind   = KIND_NT;
          res.mem_offset = {8'h00, page, a[9:0]};
        end
      end
      default: res = '0;
    endcase
  end

endmodule

// ----- rtl/cartridge_bank_mapper_irq.sv -----
// Cartridge bank mapper with cycle IRQ counter: top level.
// Each request is held in the input register, and its decoded result in the result register.
// Throughput: one request per cycle unless out_ready stalls; update and decode coincide.
// Reset (rst_n, synchronous, active low) empties both stages, loads default masks and
// clears bank, command and IRQ state; the 6000h slot comes up in RAM mode.
// Depends on cbm_pkg, cbm_regs and cbm_map.
module cartridge_bank_mapper_irq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [15:0]                   in_address,
  input  logic [7:0]                    in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_irq_line,
  output logic                          out_mem_valid,
  output logic [1:0]                    out_mem_kind,
  output logic [18:0]                   out_mem_offset,
  output logic                          out_ram_write_strobe,
  output logic                          out_audio_strobe,
  output logic [3:0]                    out_audio_reg,
  output logic [7:0]                    out_audio_data
);
  import cbm_pkg::*;

  cbm_item_t   item_r;
  logic        item_v_r;
  logic        step_en;
  cbm_state_t  st;
  cbm_result_t res;
  cbm_result_t res_r;
  logic        irq_nxt;
  logic        irq_out_r;
  logic        out_v_r;

  // Decode stage advances when the result register is free or draining
  assign step_en  = item_v_r && (!out_v_r || out_ready);
  assign in_ready = !item_v_r || step_en;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{opcode: op_t'(in_opcode), address: in_address, data: in_data};
    end
  end

  cbm_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .step_en       (step_en),
    .item          (item_r),
    .st            (st),
    .irq_level_nxt (irq_nxt)
  );

  cbm_map u_map (
    .item (item_r),
    .st   (st),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_en) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r     <= res;
      irq_out_r <= irq_nxt;
    end
  end

  assign out_valid            = out_v_r;
  assign out_irq_line         = irq_out_r;
  assign out_mem_valid        = res_r.mem_valid;
  assign out_mem_kind         = res_r.mem_kind;
  assign out_mem_offset       = res_r.mem_offset;
  assign out_ram_write_strobe = res_r.ram_write_strobe;
  assign out_audio_strobe     = res_r.audio_strobe;
  assign out_audio_reg        = res_r.audio_reg;
  assign out_audio_data       = res_r.audio_data;

endmodule

// ----- sim/tb_top.sv -----
// Testbench for cartridge_bank_mapper_irq: directed and random CPU/PPU requests, checked
// against an in-bench predictor of the bank, slot, mirroring, sound and IRQ counter state.
// Depends on cbm_pkg and the cartridge_bank_mapper_irq RTL.
`timescale 1ns / 1ps

module tb_top;
  import cbm_pkg::*;

  localparam int IDLE_PCT       = 31;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;

  // Expected response: IRQ level plus the decoded result
  typedef struct packed {
    logic        irq_line;
    cbm_result_t body;
  } mapper_resp_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_opcode = '0;
  logic [15:0]          in_address = '0;
  logic [7:0]           in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_irq_line;
  logic                 out_mem_valid;
  logic [1:0]           out_mem_kind;
  logic [18:0]          out_mem_offset;
  logic                 out_ram_write_strobe;
  logic                 out_audio_strobe;
  logic [3:0]           out_audio_reg;
  logic [7:0]           out_audio_data;

  // Predicted mapper configuration and state
  logic [5:0]  rom_mask = 6'h3F;
  logic [5:0]  ram_mask = 6'h00;
  logic        ram_fitted = 1'b1;
  logic [7:0]  chr_mask = 8'hFF;
  logic [3:0]  cmd_sel = '0;
  logic [3:0]  sound_sel = '0;
  logic [7:0]  chr_bank [CHR_SLOTS] = '{default: '0};
  logic [5:0]  prg_bank [PRG_SLOTS] = '{default: '0};
  logic [5:0]  slot_bank = '0;
  slot_mode_t  slot_mode = MODE_RAM;
  logic        slot_we = 1'b0;
  logic [1:0]  mirror = MIR_VERT;
  logic        irq_en = 1'b0;
  logic        count_en = 1'b0;
  logic        ack_due = 1'b0;
  logic [15:0] cycle_counter = '0;
  logic        irq_level = 1'b0;

  mapper_resp_t expected_q[$];
  mapper_resp_t head;

  logic gaps_on = 1'b1;
  logic stall_on = 1'b1;
  int   mismatches = 0;
  int   requests_sent = 0;
  int   results_seen = 0;
  int   irq_rises = 0;
  int   mask_settings = 0;
  int   quiet_cycles = 0;

  cartridge_bank_mapper_irq u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_address           (in_address),
    .in_data              (in_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_irq_line         (out_irq_line),
    .out_mem_valid        (out_mem_valid),
    .out_mem_kind         (out_mem_kind),
    .out_mem_offset       (out_mem_offset),
    .out_ram_write_strobe (out_ram_write_strobe),
    .out_audio_strobe     (out_audio_strobe),
    .out_audio_reg        (out_audio_reg),
    .out_audio_data       (out_audio_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the mapper state by one request and return what it should answer
  function automatic mapper_resp_t predict_response(op_t op, logic [15:0] a, logic [7:0] d);
    mapper_resp_t r;
    logic [13:0]  pa;
    logic         page;
    r = '0;
    pa = a[13:0];
    page = 1'b0;
    case (op)
      OP_CPU_WRITE: begin
        case (a[15:13])
          WIN_SLOT: begin
            if (slot_mode == MODE_RAM && ram_fitted && slot_we) begin
              r.body.mem_valid = 1'b1;
              r.body.mem_kind = KIND_PRG_RAM;
              r.body.mem_offset = {slot_bank & ram_mask, a[12:0]};
              r.body.ram_write_strobe = 1'b1;
            end
          end
          WIN_CMD: cmd_sel = d[3:0];
          WIN_PARAM: begin
            case (cmd_sel)
              CMD_SLOT: begin
                slot_we = d[7];
                slot_bank = d[5:0];
                if (d[6]) slot_mode = d[7] ? MODE_RAM : MODE_NONE;
                else slot_mode = MODE_ROM;
              end
              CMD_PRG0, CMD_PRG1, CMD_PRG2: prg_bank[2'(cmd_sel - CMD_PRG0)] = d[5:0];
              CMD_MIRROR: mirror = d[1:0];
              CMD_IRQ_CTRL: begin
                irq_en = d[0];
                count_en = d[7];
                ack_due = 1'b1;
              end
              CMD_CNT_LO: cycle_counter[7:0] = d;
              CMD_CNT_HI: cycle_counter[15:8] = d;
              default: chr_bank[cmd_sel[CHR_SEL_W-1:0]] = d;
            endcase
          end
          WIN_ASEL: sound_sel = d[3:0];
          WIN_ADATA: begin
            if (sound_sel <= AUD_LAST_LO ||
                (sound_sel >= AUD_FIRST_HI && sound_sel <= AUD_LAST_HI)) begin
              r.body.audio_strobe = 1'b1;
              r.body.audio_reg = sound_sel;
              r.body.audio_data = d;
            end
          end
          default: ;
        endcase
      end
      OP_CPU_TICK: begin
        if (ack_due) begin
          irq_level = 1'b0;
          ack_due = 1'b0;
        end
        if (count_en) begin
          cycle_counter = cycle_counter - 16'd1;
          if (cycle_counter == 16'hFFFF) begin
            if (!irq_level && irq_en) irq_rises++;
            irq_level = irq_en;
          end
        end
      end
      OP_CPU_READ: begin
        if (a[15:13] == WIN_SLOT) begin
          if (slot_mode == MODE_ROM) begin
            r.body.mem_valid = 1'b1;
            r.body.mem_kind = KIND_PRG_ROM;
            r.body.mem_offset = {slot_bank & rom_mask, a[12:0]};
          end else if (slot_mode == MODE_RAM && ram_fitted) begin
            r.body.mem_valid = 1'b1;
            r.body.mem_kind = KIND_PRG_RAM;
            r.body.mem_offset = {slot_bank & ram_mask, a[12:0]};
          end
        end else if (a[15:13] == WIN_ADATA) begin
          // top bank is hardwired to the last ROM bank
          r.body.mem_valid = 1'b1;
          r.body.mem_kind = KIND_PRG_ROM;
          r.body.mem_offset = {rom_mask, a[12:0]};
        end else if (a[15]) begin
          r.body.mem_valid = 1'b1;
          r.body.mem_kind = KIND_PRG_ROM;
          r.body.mem_offset = {prg_bank[a[14:13]] & rom_mask, a[12:0]};
        end
      end
      default: begin
        if (!pa[13]) begin
          r.body.mem_valid = 1'b1;
          r.body.mem_kind = KIND_CHR;
          r.body.mem_offset = {1'b0, chr_bank[pa[12:10]] & chr_mask, pa[9:0]};
        end else if (pa[13:8] != 6'h3F) begin
          case (mirror)
            MIR_VERT: page = pa[10];
            MIR_HORZ: page = pa[11];
            MIR_LOW:  page = 1'b0;
            default:  page = 1'b1;
          endcase
          r.body.mem_valid = 1'b1;
          r.body.mem_kind = KIND_NT;
          r.body.mem_offset = {8'd0, page, pa[9:0]};
        end
      end
    endcase
    r.irq_line = irq_level;
    return r;
  endfunction

  // Present one request, hold it until taken, then record its expected response.
  // Valid is left high on return so the next request can follow without a bubble.
  task automatic send_request(input op_t op, input logic [15:0] addr, input logic [7:0] data);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_address <= addr;
    in_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_response(op, addr, data));
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random back-pressure, compare each response with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        head = expected_q.pop_front();
        check_field("irq_line", head.irq_line, out_irq_line);
        check_field("mem_valid", head.body.mem_valid, out_mem_valid);
        check_field("mem_kind", head.body.mem_kind, out_mem_kind);
        check_field("mem_offset", head.body.mem_offset, out_mem_offset);
        check_field("ram_write_strobe", head.body.ram_write_strobe, out_ram_write_strobe);
        check_field("audio_strobe", head.body.audio_strobe, out_audio_strobe);
        check_field("audio_reg", head.body.audio_reg, out_audio_reg);
        check_field("audio_data", head.body.audio_data, out_audio_data);
      end
    end
    out_ready <= !stall_on || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog on handshake inactivity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Boundary lookups in both address spaces
  task automatic test_lookup_edges();
    send_request(OP_CPU_READ, 16'h0000, 8'h00);
    send_request(OP_CPU_READ, 16'h5FFF, 8'hFF);
    send_request(OP_CPU_READ, 16'h6000, 8'h00);
    send_request(OP_CPU_READ, 16'hFFFF, 8'h00);
    send_request(OP_PPU_READ, 16'h3F00, 8'h00);
    send_request(OP_PPU_READ, 16'h3EFF, 8'h00);
    send_request(OP_PPU_READ, 16'h7C00, 8'h00);
  endtask

  // 6000h slot: RAM with and without write enable, ROM, dropped writes
  task automatic test_low_slot();
    send_request(OP_CPU_WRITE, 16'h6000, 8'h5A);
    send_request(OP_CPU_WRITE, 16'h8000, {4'h0, CMD_SLOT});
    send_request(OP_CPU_WRITE, 16'hA000, 8'hC5);
    send_request(OP_CPU_WRITE, 16'h7FFF, 8'hA5);
    send_request(OP_CPU_WRITE, 16'hBFFF, 8'h45);
    send_request(OP_CPU_READ, 16'h6000, 8'h00);
    send_request(OP_CPU_WRITE, 16'hA000, 8'h3F);
    send_request(OP_CPU_WRITE, 16'h6000, 8'hFF);
  endtask

  // Counter load, wrap to IRQ, then acknowledge on the following tick
  task automatic test_irq_counter();
    send_request(OP_CPU_WRITE, 16'h9FFF, {4'hF, CMD_CNT_HI});
    send_request(OP_CPU_WRITE, 16'hA000, 8'h00);
    send_request(OP_CPU_WRITE, 16'h8000, {4'h0, CMD_CNT_LO});
    send_request(OP_CPU_WRITE, 16'hA000, 8'h01);
    send_request(OP_CPU_WRITE, 16'h8000, {4'h0, CMD_IRQ_CTRL});
    send_request(OP_CPU_WRITE, 16'hA000, 8'h81);
    send_request(OP_CPU_TICK, 16'h0000, 8'h00);
    send_request(OP_CPU_TICK, 16'hFFFF, 8'hFF);
    send_request(OP_CPU_WRITE, 16'hA000, 8'h00);
    send_request(OP_CPU_TICK, 16'h0000, 8'h00);
  endtask

  // Sound select of a dropped register, then a forwarded one
  task automatic test_sound_forward();
    send_request(OP_CPU_WRITE, 16'hC000, 8'h06);
    send_request(OP_CPU_WRITE, 16'hE000, 8'hFF);
    send_request(OP_CPU_WRITE, 16'hDFFF, {4'hF, AUD_LAST_HI});
    send_request(OP_CPU_WRITE, 16'hFFFF, 8'h00);
  endtask

  // Random traffic, mostly command/parameter pairs, sound pairs, tick bursts and lookups
  task automatic send_random_traffic(input int count);
    int         stop_at;
    int         pick;
    int         burst;
    logic [3:0] cmd;
    logic [7:0] value;
    logic [15:0] addr;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        cmd = 4'($urandom);
        value = 8'($urandom);
        // keep the counter small so that wraps come often
        if (cmd == CMD_CNT_HI && $urandom_range(3) != 0) value = 8'h00;
        else if (cmd == CMD_CNT_LO && $urandom_range(3) != 0) value = 8'($urandom_range(24));
        send_request(OP_CPU_WRITE, {WIN_CMD, 13'($urandom)}, {4'($urandom), cmd});
        send_request(OP_CPU_WRITE, {WIN_PARAM, 13'($urandom)}, value);
      end else if (pick < 40) begin
        send_request(OP_CPU_WRITE, {WIN_ASEL, 13'($urandom)}, 8'($urandom));
        send_request(OP_CPU_WRITE, {WIN_ADATA, 13'($urandom)}, 8'($urandom));
      end else if (pick < 55) begin
        burst = $urandom_range(1, 16);
        repeat (burst) send_request(OP_CPU_TICK, 16'($urandom), 8'($urandom));
      end else if (pick < 75) begin
        addr = $urandom_range(1) ? {WIN_SLOT, 13'($urandom)} : 16'($urandom);
        if ($urandom_range(9) < 7) send_request(OP_CPU_READ, addr, 8'($urandom));
        else send_request(OP_CPU_WRITE, addr, 8'($urandom));
      end else if (pick < 92) begin
        send_request(OP_PPU_READ, 16'($urandom), 8'($urandom));
      end else begin
        send_request(op_t'($urandom_range(3)), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // Load all mask registers while idle; junk goes in the unused upper bits
  task automatic load_mask_setting(input logic [5:0] rom, input logic [5:0] ram,
                                   input logic present, input logic [7:0] chr);
    wait_for_drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_PRG_ROM_MASK;
    cfg_wdata <= {2'($urandom), rom};
    @(posedge clk);
    cfg_index <= CFG_PRG_RAM_MASK;
    cfg_wdata <= {2'($urandom), ram};
    @(posedge clk);
    cfg_index <= CFG_RAM_PRESENT;
    cfg_wdata <= {7'($urandom), present};
    @(posedge clk);
    cfg_index <= CFG_CHR_MASK;
    cfg_wdata <= chr;
    @(posedge clk);
    // index past the last register must be ignored
    cfg_index <= CFG_CHR_MASK + 3'($urandom_range(1, 4));
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    rom_mask = rom;
    ram_mask = ram;
    ram_fitted = present;
    chr_mask = chr;
    mask_settings++;
  endtask

  // Sweep the bank masks: all clear, all set, a mid value and random ones
  task automatic test_mask_settings();
    load_mask_setting(6'h00, 6'h00, 1'b0, 8'h00);
    send_random_traffic(50);
    load_mask_setting(6'h3F, 6'h3F, 1'b1, 8'hFF);
    send_random_traffic(50);
    load_mask_setting(6'h07, 6'h03, 1'b1, 8'h0F);
    send_random_traffic(50);
    repeat (2) begin
      load_mask_setting(6'($urandom), 6'($urandom), 1'($urandom), 8'($urandom));
      send_random_traffic(50);
    end
  endtask

  // Full-rate stretch with neither side idling
  task automatic test_back_to_back();
    wait_for_drain();
    gaps_on = 1'b0;
    stall_on <= 1'b0;
    send_random_traffic(150);
    wait_for_drain();
    gaps_on = 1'b1;
    stall_on <= 1'b1;
  endtask

  task automatic test_random_traffic();
    load_mask_setting(6'($urandom), 6'($urandom), 1'b1, 8'($urandom));
    send_random_traffic(450);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_lookup_edges();
    test_low_slot();
    test_irq_counter();
    test_sound_forward();
    test_mask_settings();
    test_back_to_back();
    test_random_traffic();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d responses never arrived", expected_q.size());
      mismatches++;
    end
    $display("Sent %0d requests and checked %0d responses over %0d mask settings",
             requests_sent, results_seen, mask_settings);
    $display("IRQ raised %0d times; %0d field mismatches", irq_rises, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- cartridge_bank_mapper_irq.f -----
rtl/cbm_pkg.sv
rtl/cbm_regs.sv
rtl/cbm_map.sv
rtl/cartridge_bank_mapper_irq.sv
sim/tb_top.sv
